### hw/rtl/kfht_pkg.sv
// shared types, constants and hash helpers for the keyed flag hash table
`timescale 1ns / 1ps

package kfht_pkg;

  // table geometry; the slot count is a power of two so the home slot is a bit-select
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned NAME_BYTES  = 8;
  localparam int unsigned BYTE_CNT_W  = $clog2(NAME_BYTES + 1);

  // fixed field widths
  localparam int unsigned NAME_W = 64;
  localparam int unsigned ITEM_W = 16;
  localparam int unsigned HASH_W = 32;

  // fnv-1a constants
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

  // operation codes
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISS    = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_IGNORED = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ITEM,
    ST_PROBE
  } state_e;

  // one table slot
  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [ITEM_W-1:0] item;
    logic              flag;
  } slot_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       hash_byte;
    logic       hash_item;
    logic       probe_step;
    logic       wr_claim;
    logic       wr_flag;
    logic       wr_flag_val;
    logic       res_wr;
    logic       res_take_flag;
    logic [1:0] res_status;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       ign_in;
    logic       clr_last;
    logic       byte_end;
    logic       empty;
    logic       match;
    logic       probe_last;
    logic [1:0] op;
  } dp_stat_t;

  // multiply by the fnv prime 0x01000193 as a sum of shifts
  function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
    fnv_mul = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
  endfunction

  // fold ascii upper case to lower case, other bytes pass
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      to_lower = c + 8'h20;
    end else begin
      to_lower = c;
    end
  endfunction

endpackage

### hw/rtl/keyed_flag_hash_table.sv
// top level of the keyed flag hash table
`timescale 1ns / 1ps
// Flag table keyed by a short name and an item number, open addressing with linear probing.
// A request (cmd_i, level_name_i, item_index_i) is taken at a rising edge with start high
// and busy low. Exactly one result (flag_set_o, status_o) appears for one cycle with
// done_o high; the receiver cannot hold it off, and a new request may be taken in that
// same cycle since the result sits in its own registers.
// An ignored request answers on the cycle after it is taken. Otherwise the name is hashed
// one byte per cycle, then the item number is folded in, then the probe reads one slot per
// cycle from the slot memory until a hit, an empty slot or a full wrap of up to 1024
// probes; the result is registered and appears in the cycle after the probe ends.
// Reset clears the table with a sweep over all 1024 slots, one slot per cycle; busy stays
// high for that sweep and no request is taken.

module keyed_flag_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd_i,
  input  logic [kfht_pkg::NAME_W-1:0] level_name_i,
  input  logic [kfht_pkg::ITEM_W-1:0] item_index_i,
  output logic                        done_o,
  output logic                        flag_set_o,
  output logic [1:0]                  status_o
);

  kfht_pkg::dp_cmd_t  dp_cmd;
  kfht_pkg::dp_stat_t dp_stat;

  // sequencer
  kfht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy)
  );

  // hash, memory and result datapath
  kfht_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .level_name_i (level_name_i),
    .item_index_i (item_index_i),
    .dp_cmd_i     (dp_cmd),
    .stat_o       (dp_stat),
    .done_o       (done_o),
    .flag_set_o   (flag_set_o),
    .status_o     (status_o)
  );

  // a result is only presented once the block has returned to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result presented while busy");

  // an accepted request either starts work or answers on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither in progress nor answered");

  // a set flag is only reported with a found status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && flag_set_o) |-> (status_o == kfht_pkg::STATUS_OK))
    else $error("flag reported with a non-found status");

endmodule

### hw/rtl/kfht_ctrl.sv
// controller state machine for the keyed flag hash table
`timescale 1ns / 1ps

module kfht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  kfht_pkg::dp_stat_t stat_i,
  output kfht_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  kfht_pkg::state_e state_q, state_d;

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kfht_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kfht_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = kfht_pkg::ST_IDLE;
      end
      kfht_pkg::ST_IDLE: begin
        if (start_i && !stat_i.ign_in) state_d = kfht_pkg::ST_HASH;
      end
      kfht_pkg::ST_HASH: begin
        if (stat_i.byte_end) state_d = kfht_pkg::ST_ITEM;
      end
      kfht_pkg::ST_ITEM: begin
        state_d = kfht_pkg::ST_PROBE;
      end
      kfht_pkg::ST_PROBE: begin
        if (stat_i.empty || stat_i.match || stat_i.probe_last) state_d = kfht_pkg::ST_IDLE;
      end
      default: begin
        state_d = kfht_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      kfht_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      kfht_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.ign_in) begin
            cmd_o.res_wr     = 1'b1;
            cmd_o.res_status = kfht_pkg::STATUS_IGNORED;
          end
        end
      end
      kfht_pkg::ST_HASH: begin
        if (!stat_i.byte_end) cmd_o.hash_byte = 1'b1;
      end
      kfht_pkg::ST_ITEM: begin
        cmd_o.hash_item = 1'b1;
      end
      kfht_pkg::ST_PROBE: begin
        priority if (stat_i.empty) begin
          // empty slot ends the probe, a mark claims it
          cmd_o.res_wr = 1'b1;
          if (stat_i.op == kfht_pkg::OP_MARK) begin
            cmd_o.wr_claim   = 1'b1;
            cmd_o.res_status = kfht_pkg::STATUS_OK;
          end else begin
            cmd_o.res_status = kfht_pkg::STATUS_MISS;
          end
        end else if (stat_i.match) begin
          cmd_o.res_wr     = 1'b1;
          cmd_o.res_status = kfht_pkg::STATUS_OK;
          if (stat_i.op == kfht_pkg::OP_QUERY) begin
            cmd_o.res_take_flag = 1'b1;
          end else if (stat_i.op == kfht_pkg::OP_MARK) begin
            cmd_o.wr_flag     = 1'b1;
            cmd_o.wr_flag_val = 1'b1;
          end else begin
            cmd_o.wr_flag = 1'b1;
          end
        end else if (stat_i.probe_last) begin
          // wrapped the whole table
          cmd_o.res_wr     = 1'b1;
          cmd_o.res_status = (stat_i.op == kfht_pkg::OP_MARK) ? kfht_pkg::STATUS_FULL
                                                              : kfht_pkg::STATUS_MISS;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != kfht_pkg::ST_IDLE);

endmodule

### hw/rtl/kfht_datapath.sv
// hash, probe and slot memory datapath for the keyed flag hash table
`timescale 1ns / 1ps

module kfht_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    cmd_i,
  input  logic [kfht_pkg::NAME_W-1:0]   level_name_i,
  input  logic [kfht_pkg::ITEM_W-1:0]   item_index_i,
  input  kfht_pkg::dp_cmd_t             dp_cmd_i,
  output kfht_pkg::dp_stat_t            stat_o,
  output logic                          done_o,
  output logic                          flag_set_o,
  output logic [1:0]                    status_o
);

  // request registers
  logic [1:0]                        op_q, op_d;
  logic [kfht_pkg::NAME_W-1:0]       raw_q, raw_d;
  logic [kfht_pkg::NAME_W-1:0]       key_q, key_d;
  logic [kfht_pkg::ITEM_W-1:0]       item_q, item_d;
  logic [kfht_pkg::HASH_W-1:0]       h_q, h_d;
  logic [kfht_pkg::BYTE_CNT_W-1:0]   byte_cnt_q, byte_cnt_d;

  // probe registers
  logic [kfht_pkg::SLOT_W-1:0]       pos_q, pos_d;
  logic [kfht_pkg::SLOT_W-1:0]       cnt_q, cnt_d;

  // result registers
  logic                              done_q, done_d;
  logic                              flag_q, flag_d;
  logic [1:0]                        status_q, status_d;

  // slot memory
  kfht_pkg::slot_t                   mem_q [kfht_pkg::TABLE_SLOTS];
  kfht_pkg::slot_t                   rd_q;
  kfht_pkg::slot_t                   wdata;
  logic                              mem_we;

  logic [7:0]                        byte_lc;
  logic [kfht_pkg::HASH_W-1:0]       h_byte, h_item;

  // lower-cased current byte and the two hash steps
  assign byte_lc = kfht_pkg::to_lower(raw_q[7:0]);
  assign h_byte  = kfht_pkg::fnv_mul(h_q ^ {{(kfht_pkg::HASH_W - 8){1'b0}}, byte_lc});
  assign h_item  = kfht_pkg::fnv_mul(h_q ^ {{(kfht_pkg::HASH_W - kfht_pkg::ITEM_W){1'b0}},
                                            item_q});

  // request capture and byte-serial hashing
  always_comb begin
    op_d       = op_q;
    raw_d      = raw_q;
    key_d      = key_q;
    item_d     = item_q;
    h_d        = h_q;
    byte_cnt_d = byte_cnt_q;
    if (dp_cmd_i.load) begin
      op_d       = cmd_i;
      raw_d      = level_name_i;
      key_d      = '0;
      item_d     = item_index_i;
      h_d        = kfht_pkg::FNV_BASIS;
      byte_cnt_d = '0;
    end else if (dp_cmd_i.hash_byte) begin
      raw_d      = raw_q >> 8;
      h_d        = h_byte;
      byte_cnt_d = byte_cnt_q + 1'b1;
      for (int b = 0; b < kfht_pkg::NAME_BYTES; b++) begin
        if (byte_cnt_q == kfht_pkg::BYTE_CNT_W'(b)) key_d[8*b +: 8] = byte_lc;
      end
    end else if (dp_cmd_i.hash_item) begin
      h_d = h_item;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    raw_q      <= raw_d;
    key_q      <= key_d;
    item_q     <= item_d;
    h_q        <= h_d;
    byte_cnt_q <= byte_cnt_d;
  end

  // slot pointer and probe count; the pointer also drives the clearing sweep
  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (dp_cmd_i.clr_step) begin
      pos_d = pos_q + 1'b1;
    end else if (dp_cmd_i.hash_item) begin
      pos_d = h_item[kfht_pkg::SLOT_W-1:0];
      cnt_d = '0;
    end else if (dp_cmd_i.probe_step) begin
      pos_d = pos_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  // write data: zero on sweep, new entry on claim, flag rewrite on hit
  always_comb begin
    mem_we = dp_cmd_i.clr_step | dp_cmd_i.wr_claim | dp_cmd_i.wr_flag;
    wdata  = '0;
    if (dp_cmd_i.wr_claim) begin
      wdata.name = key_q;
      wdata.item = item_q;
      wdata.flag = 1'b1;
    end else if (dp_cmd_i.wr_flag) begin
      wdata.name = rd_q.name;
      wdata.item = rd_q.item;
      wdata.flag = dp_cmd_i.wr_flag_val;
    end
  end

  // memory: write at the current slot, read ahead at the next one
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[pos_q] <= wdata;
    rd_q <= mem_q[pos_d];
  end

  // result registers
  always_comb begin
    done_d   = dp_cmd_i.res_wr;
    flag_d   = flag_q;
    status_d = status_q;
    if (dp_cmd_i.res_wr) begin
      flag_d   = dp_cmd_i.res_take_flag & rd_q.flag;
      status_d = dp_cmd_i.res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q   <= flag_d;
    status_q <= status_d;
  end

  // status toward the controller
  always_comb begin
    stat_o.ign_in     = (cmd_i != kfht_pkg::OP_QUERY && cmd_i != kfht_pkg::OP_MARK &&
                         cmd_i != kfht_pkg::OP_CLEAR) ||
                        (item_index_i == '0) || (level_name_i[7:0] == 8'h00);
    stat_o.clr_last   = (pos_q == kfht_pkg::SLOT_W'(kfht_pkg::TABLE_SLOTS - 1));
    stat_o.byte_end   = (byte_cnt_q == kfht_pkg::BYTE_CNT_W'(kfht_pkg::NAME_BYTES)) ||
                        (raw_q[7:0] == 8'h00);
    stat_o.empty      = (rd_q.name == '0);
    stat_o.match      = (rd_q.name == key_q) && (rd_q.item == item_q);
    stat_o.probe_last = (cnt_q == kfht_pkg::SLOT_W'(kfht_pkg::TABLE_SLOTS - 1));
    stat_o.op         = op_q;
  end

  assign done_o     = done_q;
  assign flag_set_o = flag_q;
  assign status_o   = status_q;

endmodule

### dv/tb_keyed_flag_hash_table.sv
// self-checking testbench for the keyed flag hash table
`timescale 1ns / 1ps

module tb_keyed_flag_hash_table;
  import kfht_pkg::*;

  // hash prime and the command code the block does not define
  localparam logic [HASH_W-1:0] HASH_PRIME  = 32'd16777619;
  localparam logic [1:0]        OP_UNUSED   = 2'd3;
  localparam int                CLK_HALF    = 5;
  localparam longint            TIMEOUT_NS  = 64'd100_000_000;
  localparam int                DRAIN_LIMIT = 5000;
  localparam int                SETTLE_CYC  = 1100;
  localparam int                RAND_ITEMS  = 760;

  // one expected answer
  typedef struct packed {
    logic       flag_set;
    logic [1:0] status;
  } verdict_t;

  // keeps a shadow of the flag table and checks every answer against it
  class flag_table_scoreboard;
    logic [NAME_W-1:0] shadow_name[TABLE_SLOTS];
    logic [ITEM_W-1:0] shadow_item[TABLE_SLOTS];
    logic              shadow_flag[TABLE_SLOTS];
    int unsigned       used_slots;
    verdict_t          verdict_q[$];
    int                errors;
    int                checked;
    int                status_seen[4];

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        shadow_name[i] = '0;
        shadow_item[i] = '0;
        shadow_flag[i] = 1'b0;
      end
      used_slots = 0;
      errors     = 0;
      checked    = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    // the block drops bad commands, item zero and empty names
    static function bit is_dropped(logic [1:0] op, logic [NAME_W-1:0] raw,
                                   logic [ITEM_W-1:0] item);
      return (op == OP_UNUSED) || (item == '0) || (raw[7:0] == 8'h00);
    endfunction

    // apply one request to the shadow table and queue its answer
    function void note_request(logic [1:0] op, logic [NAME_W-1:0] raw,
                               logic [ITEM_W-1:0] item);
      logic [NAME_W-1:0] key;
      logic [HASH_W-1:0] h;
      logic [7:0]        c;
      int unsigned       pos;
      int                i;
      int                n;
      bit                cut;
      bit                resolved;
      verdict_t          v;
      v.flag_set = 1'b0;
      v.status   = STATUS_IGNORED;
      if (!is_dropped(op, raw, item)) begin
        // canonical name and fnv-1a over its bytes
        key = '0;
        h   = FNV_BASIS;
        cut = 1'b0;
        for (i = 0; i < NAME_BYTES; i++) begin
          c = raw[8*i +: 8];
          if (c == 8'h00) cut = 1'b1;
          if (!cut) begin
            if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
            key[8*i +: 8] = c;
            h = (h ^ {24'd0, c}) * HASH_PRIME;
          end
        end
        h   = (h ^ {16'd0, item}) * HASH_PRIME;
        pos = h % TABLE_SLOTS;
        // linear probe with wrap
        resolved = 1'b0;
        v.status = STATUS_MISS;
        for (n = 0; n < TABLE_SLOTS && !resolved; n++) begin
          if (shadow_name[pos] == '0) begin
            if (op == OP_MARK) begin
              shadow_name[pos] = key;
              shadow_item[pos] = item;
              shadow_flag[pos] = 1'b1;
              used_slots++;
              v.status = STATUS_OK;
            end else begin
              v.status = STATUS_MISS;
            end
            resolved = 1'b1;
          end else if (shadow_name[pos] == key && shadow_item[pos] == item) begin
            if (op == OP_QUERY) v.flag_set = shadow_flag[pos];
            else if (op == OP_MARK) shadow_flag[pos] = 1'b1;
            else shadow_flag[pos] = 1'b0;
            v.status = STATUS_OK;
            resolved = 1'b1;
          end
          pos = (pos + 1) % TABLE_SLOTS;
        end
        if (!resolved) v.status = (op == OP_MARK) ? STATUS_FULL : STATUS_MISS;
      end
      verdict_q.push_back(v);
    endfunction

    // compare one answer with the oldest expectation
    function void check_result(logic flag_set, logic [1:0] status);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("answer with no request pending: flag_set %0b status %0d",
               flag_set, status);
        errors++;
      end else begin
        v = verdict_q.pop_front();
        checked++;
        status_seen[v.status]++;
        if (flag_set !== v.flag_set) begin
          $error("flag_set: expected %0b, actual %0b", v.flag_set, flag_set);
          errors++;
        end
        if (status !== v.status) begin
          $error("status: expected %0d, actual %0d", v.status, status);
          errors++;
        end
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic [1:0]          cmd_i        = OP_QUERY;
  logic [NAME_W-1:0]   level_name_i = '0;
  logic [ITEM_W-1:0]   item_index_i = '0;
  logic                busy;
  logic                done_o;
  logic                flag_set_o;
  logic [1:0]          status_o;

  flag_table_scoreboard sb = new();

  string name_pool[8] = '{"castle", "Dungeon1", "lv", "z", "ab@[`{", "ABCDEFGH",
                          "q_7", "Mire"};
  int    burst_left = 0;
  int    sent_cnt   = 0;

  keyed_flag_hash_table u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .level_name_i (level_name_i),
    .item_index_i (item_index_i),
    .done_o       (done_o),
    .flag_set_o   (flag_set_o),
    .status_o     (status_o)
  );

  // clock
  always #CLK_HALF clk_i = ~clk_i;

  // watch handshakes; an answer at this edge belongs to an older request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(flag_set_o, status_o);
      if (start && !busy) sb.note_request(cmd_i, level_name_i, item_index_i);
    end
  end

  // pack a string into name bytes, first character low
  function automatic logic [NAME_W-1:0] pack_name(string s);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < s.len() && i < NAME_BYTES; i++) n[8*i +: 8] = s[i];
    return n;
  endfunction

  // random case flips and junk after the terminating zero
  function automatic logic [NAME_W-1:0] vary_name(logic [NAME_W-1:0] n);
    logic [7:0] c;
    int         len;
    len = NAME_BYTES;
    for (int i = NAME_BYTES - 1; i >= 0; i--) begin
      if (n[8*i +: 8] == 8'h00) len = i;
    end
    for (int i = 0; i < len; i++) begin
      c = n[8*i +: 8];
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
        n[8*i +: 8] = c ^ 8'h20;
    end
    if ($urandom_range(0, 1)) begin
      for (int i = len + 1; i < NAME_BYTES; i++) n[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return n;
  endfunction

  // hold start low for some cycles
  task automatic idle(int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // offer one request and wait until the block takes it
  task automatic send(logic [1:0] op, logic [NAME_W-1:0] name, logic [ITEM_W-1:0] item);
    bit taken;
    @(negedge clk_i);
    start        <= 1'b1;
    cmd_i        <= op;
    level_name_i <= name;
    item_index_i <= item;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    sent_cnt++;
  endtask

  // bursts of back-to-back requests separated by random gaps
  task automatic send_paced(logic [1:0] op, logic [NAME_W-1:0] name, logic [ITEM_W-1:0] item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) idle(gap);
    end
    burst_left--;
    send(op, name, item);
  endtask

  // one random request: mostly pool keys, some noise
  task automatic send_random();
    logic [1:0]        op;
    logic [NAME_W-1:0] name;
    logic [ITEM_W-1:0] item;
    int                pick;
    if ($urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 40) ? OP_MARK : (pick < 75) ? OP_QUERY : OP_CLEAR;
      name = vary_name(pack_name(name_pool[$urandom_range(0, 7)]));
      pick = $urandom_range(0, 19);
      item = (pick < 16) ? ITEM_W'($urandom_range(1, 6)) : (pick < 18) ? 16'hFFFF
                         : ITEM_W'($urandom_range(1, 65535));
    end else begin
      op   = 2'($urandom_range(0, 3));
      name = {$urandom, $urandom};
      item = ITEM_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      if (pick == 0) item = '0;
      else if (pick == 1) name[7:0] = 8'h00;
      else if (pick == 2) name = vary_name(pack_name(name_pool[$urandom_range(0, 7)]));
    end
    send_paced(op, name, item);
  endtask

  // stimulus and end of run
  initial begin
    int                wait_cyc;
    int                rand_start;
    logic [NAME_W-1:0] castle;
    castle = pack_name("Castle");
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: hits, misses, clear semantics, case folding, drops, extremes
    send(OP_QUERY, castle, 16'd1);
    send(OP_MARK,  castle, 16'd1);
    send(OP_QUERY, pack_name("castle"), 16'd1);
    send(OP_QUERY, castle | 64'hA500_0000_0000_0000, 16'd1);
    send(OP_QUERY, castle, 16'd2);
    send(OP_CLEAR, pack_name("CASTLE"), 16'd1);
    send(OP_QUERY, castle, 16'd1);
    send(OP_CLEAR, castle, 16'd1);
    send(OP_MARK,  castle, 16'd1);
    send(OP_QUERY, castle, 16'd1);
    send(OP_CLEAR, pack_name("nowhere"), 16'd9);
    send(OP_MARK,  castle, 16'd0);
    send(OP_MARK,  64'hFFFF_FFFF_FFFF_FF00, 16'd5);
    send(OP_UNUSED, castle, 16'd1);
    send(OP_MARK,  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send(OP_MARK,  pack_name("ABCDEFGH"), 16'hFFFF);
    send(OP_QUERY, pack_name("abcdefgh"), 16'hFFFF);
    send(OP_MARK,  pack_name("@x"), 16'd3);
    send(OP_QUERY, pack_name("`x"), 16'd3);
    send(OP_QUERY, pack_name("@X"), 16'd3);
    send(OP_MARK,  pack_name("[{"), 16'd1);
    send(OP_QUERY, pack_name("{["), 16'd1);
    send(OP_QUERY, 64'h0000_0000_0000_0001, 16'd1);

    // random traffic
    rand_start = sent_cnt;
    while (sent_cnt - rand_start < RAND_ITEMS) send_random();

    // late requests on keys never marked and on marked ones
    send(OP_MARK,  pack_name("newkey"), 16'd1);
    send(OP_MARK,  pack_name("newkey"), 16'hFFFF);
    send(OP_QUERY, pack_name("newkey"), 16'd1);
    send(OP_CLEAR, pack_name("newkey"), 16'd2);
    send(OP_QUERY, pack_name("NEWKEY"), 16'd1);
    send(OP_CLEAR, pack_name("newKey"), 16'd1);
    send(OP_QUERY, pack_name("newkey"), 16'd1);
    send(OP_MARK,  pack_name("newkey"), 16'd1);
    send(OP_QUERY, pack_name("newkey"), 16'd1);
    send(OP_MARK,  castle, 16'd0);
    idle(1);

    // drain outstanding answers, then watch for strays
    wait_cyc = 0;
    while (sb.pending() > 0 && wait_cyc < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    if (sb.pending() > 0) begin
      $error("%0d answers never arrived", sb.pending());
      sb.errors++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("checked %0d answers: %0d ok, %0d miss, %0d full, %0d dropped",
             sb.checked, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_MISS],
             sb.status_seen[STATUS_FULL], sb.status_seen[STATUS_IGNORED]);
    $display("table filled to %0d of %0d slots, %0d errors",
             sb.used_slots, TABLE_SLOTS, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
